// ===== rtl/ssema_pkg.sv =====
// Shared types and constants for the SMA-seeded EMA filter.
package ssema_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned WIN_W    = 11;
    localparam int unsigned ALPHA_W  = 17;
    localparam int unsigned SUM_W    = 43;
    localparam int unsigned PROD_W   = 51;
    localparam int unsigned DIV_W    = 43;
    localparam int unsigned DCNT_W   = 6;

    localparam logic [WIN_W-1:0]  WIN_RESET  = 11'd14;
    localparam logic [WIN_W-1:0]  MAX_WINDOW = 11'd1024;
    localparam logic [DIV_W-1:0]  ALPHA_NUM  = 43'd131072;
    localparam logic [DCNT_W-1:0] DIV_LAST   = 6'(DIV_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALPHA,
        ST_STEP,
        ST_SEED_GO,
        ST_SEED,
        ST_UPDATE,
        ST_EMIT
    } ssema_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic start_alpha;
        logic load_alpha;
        logic accum;
        logic start_seed;
        logic load_seed;
        logic ema_mul;
        logic ema_update;
        logic out_load;
    } ssema_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_start;
        logic seeding;
        logic seed_last;
        logic div_done;
        logic out_free;
    } ssema_stat_t;

endpackage

// ===== rtl/sma_seeded_ema_filter.sv =====
// Steady EMA beats and seeding beats each pass through an emit step before the next accept.
// The last seed beat adds the mean division and a series start adds the alpha
// division. Both run on one shared bit-serial divider.
// The result is loaded into the output register in the emit state, once that register is free.
// Asynchronous active-low reset: idle, window 14, no series open.
module sma_seeded_ema_filter
    import ssema_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [WIN_W-1:0]           cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       first_of_series,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] average,
    output logic                       average_valid
);

    ssema_cmd_t  cmd;
    ssema_stat_t stat;

    ssema_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssema_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .sample          (sample),
        .first_of_series (first_of_series),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .average         (average),
        .average_valid   (average_valid),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

// ===== rtl/ssema_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module ssema_div
    import ssema_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [WIN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [WIN_W-1:0]  dsr_reg, dsr_next;
    logic [WIN_W:0]    rem_sh;
    logic [WIN_W:0]    trial;

    // one shift-subtract step
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        trial     = rem_sh - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[WIN_W])
            begin
                rem_next = trial[WIN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WIN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/ssema_dp.sv =====
// Datapath: window register, seed sum, alpha, EMA update and output register.
module ssema_dp
    import ssema_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [WIN_W-1:0]           cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       first_of_series,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] average,
    output logic                       average_valid,
    input  ssema_cmd_t                 cmd,
    output ssema_stat_t                stat
);

    logic [WIN_W-1:0]           window_length_reg;
    logic                       active_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [WIN_W-1:0]           series_window_reg;
    logic [ALPHA_W-1:0]         alpha_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [WIN_W-1:0]           seen_reg;
    logic signed [SAMPLE_W-1:0] last_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] res_avg_reg;
    logic                       res_valid_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_avg_reg;
    logic                       out_avg_valid_reg;

    logic [WIN_W-1:0]           eff_win;
    logic [WIN_W-1:0]           eff_win_p1;
    logic                       div_start;
    logic [DIV_W-1:0]           div_dividend;
    logic [WIN_W-1:0]           div_divisor;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quo;
    logic [SUM_W-1:0]           sum_mag;
    logic [SAMPLE_W-1:0]        seed_q;
    logic signed [SAMPLE_W-1:0] seed_avg;
    logic signed [SAMPLE_W:0]   ema_diff;
    logic signed [SAMPLE_W+2:0] ema_sum;
    logic [WIN_W:0]             seen_p1;

    // window clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (window_length_reg == '0)
            eff_win = WIN_W'(1);
        else if (window_length_reg > MAX_WINDOW)
            eff_win = MAX_WINDOW;
        else
            eff_win = window_length_reg;
        eff_win_p1 = eff_win + 1'b1;
    end

    // divider operands: alpha at series start, mean at end of seed
    always_comb
    begin
        sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_start = cmd.start_alpha | cmd.start_seed;
        if (cmd.start_alpha)
        begin
            div_dividend = ALPHA_NUM + DIV_W'(eff_win_p1 >> 1);
            div_divisor  = eff_win_p1;
        end
        else
        begin
            div_dividend = sum_mag;
            div_divisor  = series_window_reg;
        end
    end

    ssema_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // seed mean and EMA arithmetic
    always_comb
    begin
        seed_q   = div_quo[SAMPLE_W-1:0];
        seed_avg = neg_reg ? $signed(-seed_q) : $signed(seed_q);
        ema_diff = {x_reg[SAMPLE_W-1], x_reg} - {last_reg[SAMPLE_W-1], last_reg};
        ema_sum  = {{3{last_reg[SAMPLE_W-1]}}, last_reg} + prod_reg[PROD_W-1:16];
        seen_p1  = {1'b0, seen_reg} + 1'b1;
    end

    // status
    always_comb
    begin
        stat.need_start = first_of_series | ~active_reg;
        stat.seeding    = seen_reg < series_window_reg;
        stat.seed_last  = seen_p1 == {1'b0, series_window_reg};
        stat.div_done   = div_done;
        stat.out_free   = ~out_valid_reg | out_ready;
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WIN_RESET;
            active_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                window_length_reg <= cfg_wr_data;
            if (cmd.load_alpha)
                active_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= sample;
            if (stat.need_start)
                series_window_reg <= eff_win;
        end
        if (cmd.load_alpha)
        begin
            alpha_reg <= div_quo[ALPHA_W-1:0];
            sum_reg   <= '0;
            seen_reg  <= '0;
            last_reg  <= '0;
        end
        if (cmd.accum)
        begin
            sum_reg     <= sum_reg + SUM_W'(x_reg);
            seen_reg    <= seen_reg + 1'b1;
            res_avg_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        if (cmd.start_seed)
            neg_reg <= sum_reg[SUM_W-1];
        if (cmd.load_seed)
        begin
            res_avg_reg   <= seed_avg;
            res_valid_reg <= 1'b1;
            last_reg      <= seed_avg;
        end
        if (cmd.ema_mul)
            prod_reg <= PROD_W'($signed({1'b0, alpha_reg}) * ema_diff);
        if (cmd.ema_update)
        begin
            res_avg_reg   <= ema_sum[SAMPLE_W-1:0];
            res_valid_reg <= 1'b1;
            last_reg      <= ema_sum[SAMPLE_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_avg_reg       <= res_avg_reg;
            out_avg_valid_reg <= res_valid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average       = out_avg_reg;
    assign average_valid = out_avg_valid_reg;

endmodule

// ===== rtl/ssema_ctrl.sv =====
// Controller: sequences series start, seeding, seed division and EMA update.
module ssema_ctrl
    import ssema_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ssema_stat_t stat,
    output ssema_cmd_t  cmd
);

    ssema_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.need_start)
                    begin
                        cmd.start_alpha = 1'b1;
                        state_next      = ST_ALPHA;
                    end
                    else
                        state_next = ST_STEP;
                end
            end
            ST_ALPHA:
            begin
                if (stat.div_done)
                begin
                    cmd.load_alpha = 1'b1;
                    state_next     = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (stat.seeding)
                begin
                    cmd.accum  = 1'b1;
                    state_next = stat.seed_last ? ST_SEED_GO : ST_EMIT;
                end
                else
                begin
                    cmd.ema_mul = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_SEED_GO:
            begin
                cmd.start_seed = 1'b1;
                state_next     = ST_SEED;
            end
            ST_SEED:
            begin
                if (stat.div_done)
                begin
                    cmd.load_seed = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_UPDATE:
            begin
                cmd.ema_update = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/ssema_chk.sv =====
// Port-level checker for the filter, bound to the top level.
module ssema_chk
    import ssema_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] average,
    input logic                       average_valid
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average) && $stable(average_valid))
        else $error("output beat changed while stalled");

    // an invalid result carries a zero average
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !average_valid |-> average == '0)
        else $error("invalid result with non-zero average");

    // one beat in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

    // a new result only appears after the block has been working
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work");

endmodule

bind sma_seeded_ema_filter ssema_chk u_chk (.*);

// ===== tb/sv/sma_seeded_ema_filter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the SMA-seeded EMA filter, with directed and random series.
module sma_seeded_ema_filter_tb;
    import ssema_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 100;   // two divisions plus a beat
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 40;
    localparam int RAND_PHASES  = 12;
    localparam int LONG_ITEMS   = 150;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] S_ONE = 32'sh0001_0000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic                       average_valid;
    } avg_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [WIN_W-1:0]           cfg_wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_series;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] average;
    logic                       average_valid;

    // expected averages, oldest first
    avg_result_t expected_averages[$];

    // filter state as predicted
    logic [WIN_W-1:0]           win_reg;
    int unsigned                ser_window;
    int unsigned                seen;
    int unsigned                alpha;
    longint                     run_sum;
    logic signed [SAMPLE_W-1:0] prev_avg;

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int items_sent;
    int series_count;
    int valid_count;
    int window_writes;
    int cycle_count = 0;

    sma_seeded_ema_filter i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .first_of_series (first_of_series),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .average         (average),
        .average_valid   (average_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle limit with %0d averages pending",
                     expected_averages.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each output beat against the oldest prediction
    always @(posedge clk)
    begin
        avg_result_t exp_r;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_averages.size() == 0)
            begin
                $error("unexpected result: average=%0d average_valid=%0b",
                       average, average_valid);
                error_count++;
            end
            else
            begin
                exp_r = expected_averages.pop_front();
                if (average !== exp_r.average)
                begin
                    $error("average: expected %0d, got %0d", exp_r.average, average);
                    error_count++;
                end
                if (average_valid !== exp_r.average_valid)
                begin
                    $error("average_valid: expected %0b, got %0b",
                           exp_r.average_valid, average_valid);
                    error_count++;
                end
                if (exp_r.average_valid)
                    valid_count++;
            end
        end
    end

    // seeded EMA prediction for one accepted sample
    function automatic avg_result_t ema_predict(logic signed [SAMPLE_W-1:0] x,
                                                logic new_series);
        int unsigned w;
        longint      a;
        longint      acc;
        avg_result_t r;
        r.average       = '0;
        r.average_valid = 1'b0;
        // series start latches window and smoothing factor
        if (new_series || ser_window == 0)
        begin
            w = win_reg;
            if (w == 0)
                w = 1;
            if (w > MAX_WINDOW)
                w = MAX_WINDOW;
            ser_window = w;
            alpha      = (131072 + (w + 1) / 2) / (w + 1);
            run_sum    = 0;
            seen       = 0;
            prev_avg   = '0;
            series_count++;
        end
        if (seen < ser_window)
        begin
            run_sum += longint'(x);
            seen++;
            if (seen == ser_window)
            begin
                prev_avg        = SAMPLE_W'(run_sum / longint'(ser_window));
                r.average       = prev_avg;
                r.average_valid = 1'b1;
            end
        end
        else
        begin
            a               = longint'(alpha);
            acc             = a * longint'(x) + (65536 - a) * longint'(prev_avg);
            prev_avg        = SAMPLE_W'(acc >>> 16);
            r.average       = prev_avg;
            r.average_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0: v = S_MAX;
            1: v = S_MIN;
            2, 3, 4: v = SAMPLE_W'($signed(17'($urandom)));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int unsigned eff_window(logic [WIN_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WINDOW)
            return MAX_WINDOW;
        return w;
    endfunction

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            IDLE_BOTH: begin send_idle_pct = 24; recv_stall_pct = 24; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // one sample beat, with random idle cycles ahead of it
    task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic new_series);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        sample          <= x;
        first_of_series <= new_series;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        expected_averages.push_back(ema_predict(x, new_series));
        items_sent++;
    endtask

    // stop sending and let every pending average come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] w);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        win_reg = w;
        window_writes++;
    endtask

    // reset window of 14, first beat opens a series without the flag
    task automatic test_reset_series();
        logic signed [SAMPLE_W-1:0] vals[15];
        vals = '{S_MAX, S_MIN, 0, -1, S_ONE, S_MAX, S_MAX, S_MIN, 1, -S_ONE,
                 S_MAX, S_MIN, 32'sh5555_5555, 32'shAAAA_AAAA, S_MIN};
        set_idling(IDLE_NONE);
        foreach (vals[i])
            send_sample(vals[i], 1'b0);
        drain();
    endtask

    // window zero acts as one: alpha is unity, average follows the input
    task automatic test_window_one();
        write_window('0);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(-1, 1'b0);
        drain();
    endtask

    // series cut short by a restart gives an invalid beat, then the new series seeds
    task automatic test_short_series();
        write_window(11'd2);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MAX, 1'b0);
        drain();
    endtask

    // new window only takes effect at the next series start
    task automatic test_window_mid_series();
        write_window(11'd3);
        send_sample(S_ONE, 1'b1);
        send_sample(-S_ONE, 1'b0);
        drain();
        write_window(11'd1);
        send_sample(32'sh0003_0000, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b1);
        drain();
    endtask

    // oversized window saturates, then a long seeding stretch at a large window
    task automatic test_saturated_window();
        write_window(11'd2047);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        drain();
        write_window(11'd1500);
        set_idling(IDLE_RECV);
        for (int i = 0; i < LONG_ITEMS; i++)
            send_sample(($urandom_range(3) == 0) ? pick_sample()
                        : ($urandom_range(1) ? S_MAX : S_MIN), i == 0);
        drain();
        write_window(MAX_WINDOW);
        set_idling(IDLE_NONE);
        send_sample(S_MIN, 1'b1);
        drain();
    endtask

    // random series across windows and idling patterns
    task automatic test_random_series();
        int unsigned w;
        int          len;
        int          phase_items;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_idling(idle_mode_t'(p % 4));
            if (p == 0)
                write_window(11'd1);
            else if (p == RAND_PHASES - 1)
                write_window(11'd0);
            else
                write_window(WIN_W'($urandom_range(40, 0)));
            w = eff_window(win_reg);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 15 && w > 1)
                    len = $urandom_range(w - 1, 1);
                else
                    len = w + $urandom_range(40);
                for (int k = 0; k < len; k++)
                    send_sample(pick_sample(), k == 0 || $urandom_range(99) < 2);
                phase_items += len;
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        sample          = '0;
        first_of_series = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        error_count     = 0;
        items_sent      = 0;
        series_count    = 0;
        valid_count     = 0;
        window_writes   = 0;
        win_reg         = WIN_RESET;
        ser_window      = 0;
        seen            = 0;
        alpha           = 0;
        run_sum         = 0;
        prev_avg        = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_series();
        test_window_one();
        test_short_series();
        test_window_mid_series();
        test_saturated_window();
        test_random_series();

        $display("Run covered %0d samples in %0d series, %0d valid averages checked",
                 items_sent, series_count, valid_count);
        $display("Window register written %0d times, including zero and saturating values",
                 window_writes);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
